/* design/feq_pkg.sv */
// Shared constants, types and helpers for the fan-out event queue.
`default_nettype none
package feq_pkg;

  localparam int NUM_DEVICES        = 4;
  localparam int CLIENTS_PER_DEVICE = 4;
  localparam int QUEUE_DEPTH        = 128;
  localparam int NSLOTS             = NUM_DEVICES * CLIENTS_PER_DEVICE;
  localparam int SLOT_W             = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int PTR_W              = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W             = $clog2(NSLOTS * QUEUE_DEPTH);
  localparam int CI_W               = (CLIENTS_PER_DEVICE > 1) ? $clog2(CLIENTS_PER_DEVICE) : 1;
  localparam int MAXEV_W            = 7;
  localparam int MAX_RESULTS        = 64;
  localparam int CMP_W              = ((PTR_W > MAXEV_W) ? PTR_W : MAXEV_W) + 1;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_READ   = 3'd1,
    CMD_OPEN   = 3'd2,
    CMD_CLOSE  = 3'd3,
    CMD_STATUS = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NODEV   = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_NOTOPEN = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_RD_REQ,
    S_RD_OUT,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [1:0]           dev;
    logic [1:0]           slot;
    logic [15:0]          etype;
    logic [15:0]          ecode;
    logic [31:0]          evalue;
    logic [63:0]          ts;
    logic [MAXEV_W-1:0]   maxev;
  } cmd_item_t;

  typedef struct packed {
    status_t      st;
    logic [1:0]   aslot;
    logic [15:0]  otype;
    logic [15:0]  ocode;
    logic [31:0]  ovalue;
    logic [63:0]  ots;
    logic         last;
    logic         has_events;
    logic         client_present;
    logic [31:0]  dropped;
    logic [31:0]  oseq;
  } res_item_t;

  // Ring pointer increment with wrap at the ring depth.
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/feq_cmd_queue.sv */
// Front end: accepts items, drops unknown commands, clamps read size, queues the rest.
`default_nettype none
module feq_cmd_queue
  import feq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         command,
  input  wire logic [1:0]         device,
  input  wire logic [1:0]         client_slot,
  input  wire logic [15:0]        event_type,
  input  wire logic [15:0]        event_code,
  input  wire logic [31:0]        event_value,
  input  wire logic [63:0]        timestamp,
  input  wire logic [MAXEV_W-1:0] max_events,
  output logic                    cmd_valid,
  output cmd_item_t               cmd_item,
  input  wire logic               cmd_pop
);

  cmd_item_t  entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       known;
  logic       wr;
  logic       rd;
  cmd_item_t  in_item;

  // Classify the incoming item; read size is clamped to 1..64 here.
  always_comb begin
    known = (command <= CMD_STATUS);
    in_item.cmd    = cmd_t'(command);
    in_item.dev    = device;
    in_item.slot   = client_slot;
    in_item.etype  = event_type;
    in_item.ecode  = event_code;
    in_item.evalue = event_value;
    in_item.ts     = timestamp;
    if (max_events == '0) begin
      in_item.maxev = MAXEV_W'(1);
    end else if (max_events > MAXEV_W'(MAX_RESULTS)) begin
      in_item.maxev = MAXEV_W'(MAX_RESULTS);
    end else begin
      in_item.maxev = max_events;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd_item  = entry[rptr];
  assign wr        = push && !full && known;
  assign rd        = cmd_pop && cmd_valid;

  // Two-entry queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/feq_engine.sv */
// Back end: executes queued commands against the slot state and the ring memory.
`default_nettype none
module feq_engine
  import feq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic [3:0] mask,
  input  wire logic      cmd_valid,
  input  cmd_item_t      cmd_item,
  output logic           cmd_pop,
  input  wire logic      res_full,
  output logic           res_push,
  output res_item_t      res_item
);

  state_t             state;
  state_t             state_next;
  cmd_item_t          cur;
  status_t            st_code;
  logic [1:0]         aslot;
  logic [CI_W-1:0]    iter;
  logic [MAXEV_W-1:0] rd_left;
  logic               rd_more;

  logic               slot_open [NSLOTS];
  logic [PTR_W-1:0]   head      [NSLOTS];
  logic [PTR_W-1:0]   tail      [NSLOTS];
  logic [31:0]        dropped   [NSLOTS];
  logic [31:0]        seq       [NUM_DEVICES];

  logic [127:0]       ring_mem  [NSLOTS * QUEUE_DEPTH];
  logic [127:0]       rd_data;

  logic               dev_ok;
  logic               reg_ok;
  logic [SLOT_W-1:0]  sbase;
  logic [SLOT_W-1:0]  s_idx;
  logic               sl_ok;
  logic               any_open;
  logic               free_found;
  logic [1:0]         free_idx;
  logic [SLOT_W-1:0]  push_idx;
  logic [PTR_W-1:0]   count_s;
  logic [1:0]         sum_slot;
  logic [SLOT_W-1:0]  sum_idx;
  logic               sum_ok;
  logic               rd_done;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  // Decode of the command under execution.
  always_comb begin
    dev_ok   = (int'(cur.dev) < NUM_DEVICES);
    reg_ok   = dev_ok && mask[cur.dev];
    sbase    = SLOT_W'(cur.dev) * SLOT_W'(CLIENTS_PER_DEVICE);
    s_idx    = sbase + SLOT_W'(cur.slot);
    sl_ok    = dev_ok && (int'(cur.slot) < CLIENTS_PER_DEVICE) && slot_open[s_idx];
    push_idx = sbase + SLOT_W'(iter);
    any_open   = 1'b0;
    free_found = 1'b0;
    free_idx   = 2'd0;
    for (int i = 0; i < CLIENTS_PER_DEVICE; i++) begin
      if (slot_open[sbase + SLOT_W'(i)]) begin
        any_open = 1'b1;
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = 2'(i);
      end
    end
    if (tail[s_idx] >= head[s_idx]) count_s = tail[s_idx] - head[s_idx];
    else count_s = tail[s_idx] + PTR_W'(QUEUE_DEPTH) - head[s_idx];
    rd_done = (rd_left == MAXEV_W'(1)) || (ptr_adv(head[s_idx]) == tail[s_idx]);
    wr_addr = ADDR_W'(push_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail[push_idx]);
    rd_addr = ADDR_W'(s_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[s_idx]);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (!dev_ok || (((cur.cmd == CMD_PUSH) || (cur.cmd == CMD_OPEN)) && !reg_ok)) begin
          state_next = S_EMIT;
        end else if (cur.cmd == CMD_PUSH) begin
          state_next = S_PUSH;
        end else if ((cur.cmd == CMD_READ) && sl_ok && (head[s_idx] != tail[s_idx])) begin
          state_next = S_RD_REQ;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_PUSH:   if (iter == CI_W'(CLIENTS_PER_DEVICE - 1)) state_next = S_EMIT;
      S_RD_REQ: state_next = S_RD_OUT;
      S_RD_OUT: if (!res_full) state_next = rd_done ? S_IDLE : S_RD_REQ;
      S_EMIT:   if (!res_full) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake outputs and the result being offered.
  always_comb begin
    cmd_pop  = (state == S_IDLE) && cmd_valid;
    res_push = ((state == S_EMIT) || (state == S_RD_OUT)) && !res_full;
    sum_slot = ((cur.cmd == CMD_OPEN) && (st_code == ST_OK)) ? aslot : cur.slot;
    sum_idx  = sbase + SLOT_W'(sum_slot);
    sum_ok   = dev_ok && (int'(sum_slot) < CLIENTS_PER_DEVICE) && slot_open[sum_idx];
    res_item.st             = st_code;
    res_item.aslot          = aslot;
    res_item.otype          = '0;
    res_item.ocode          = '0;
    res_item.ovalue         = '0;
    res_item.ots            = '0;
    res_item.last           = 1'b1;
    res_item.has_events     = sum_ok && (head[sum_idx] != tail[sum_idx]);
    res_item.client_present = dev_ok && any_open;
    res_item.dropped        = sum_ok ? dropped[sum_idx] : 32'd0;
    res_item.oseq           = dev_ok ? seq[cur.dev] : 32'd0;
    if (state == S_RD_OUT) begin
      res_item.st         = ST_OK;
      res_item.aslot      = 2'd0;
      res_item.otype      = rd_data[127:112];
      res_item.ocode      = rd_data[111:96];
      res_item.ovalue     = rd_data[95:64];
      res_item.ots        = rd_data[63:0];
      res_item.last       = rd_done;
      res_item.has_events = rd_more;
    end
  end

  // Ring memory: one write port for pushes, one registered read port for reads.
  always_ff @(posedge clk) begin
    if ((state == S_PUSH) && slot_open[push_idx]) begin
      ring_mem[wr_addr] <= {cur.etype, cur.ecode, cur.evalue, cur.ts};
    end
    if (state == S_RD_REQ) begin
      rd_data <= ring_mem[rd_addr];
    end
  end

  // Command register and per-command working registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      cur <= cmd_item;
    end
    if (state == S_EXEC) begin
      iter    <= '0;
      aslot   <= 2'd0;
      st_code <= ST_OK;
      rd_left <= cur.maxev;
      rd_more <= CMP_W'(count_s) > CMP_W'(cur.maxev);
      if (!dev_ok || (((cur.cmd == CMD_PUSH) || (cur.cmd == CMD_OPEN)) && !reg_ok)) begin
        st_code <= ST_NODEV;
      end else if (cur.cmd == CMD_OPEN) begin
        if (!free_found) st_code <= ST_NOSLOT;
        else aslot <= free_idx;
      end else if (cur.cmd != CMD_PUSH) begin
        if (!sl_ok) st_code <= ST_NOTOPEN;
        else if ((cur.cmd == CMD_READ) && (head[s_idx] == tail[s_idx])) st_code <= ST_EMPTY;
      end
    end
    if (state == S_PUSH) begin
      iter <= iter + CI_W'(1);
    end
    if ((state == S_RD_OUT) && !res_full) begin
      rd_left <= rd_left - MAXEV_W'(1);
    end
  end

  // Slot and device state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < NSLOTS; i++) begin
        slot_open[i] <= 1'b0;
        head[i]      <= '0;
        tail[i]      <= '0;
        dropped[i]   <= '0;
      end
      for (int d = 0; d < NUM_DEVICES; d++) begin
        seq[d] <= '0;
      end
    end else begin
      state <= state_next;
      if ((state == S_EXEC) && reg_ok && (cur.cmd == CMD_OPEN) && free_found) begin
        slot_open[sbase + SLOT_W'(free_idx)] <= 1'b1;
        head[sbase + SLOT_W'(free_idx)]      <= '0;
        tail[sbase + SLOT_W'(free_idx)]      <= '0;
        dropped[sbase + SLOT_W'(free_idx)]   <= '0;
        seq[cur.dev]                         <= seq[cur.dev] + 32'd1;
      end
      if ((state == S_EXEC) && dev_ok && (cur.cmd == CMD_CLOSE) && sl_ok) begin
        slot_open[s_idx] <= 1'b0;
      end
      // One slot of the device per cycle; a full ring loses its oldest event.
      if ((state == S_PUSH) && slot_open[push_idx]) begin
        if (ptr_adv(tail[push_idx]) == head[push_idx]) begin
          head[push_idx]    <= ptr_adv(head[push_idx]);
          dropped[push_idx] <= dropped[push_idx] + 32'd1;
        end
        tail[push_idx] <= ptr_adv(tail[push_idx]);
      end
      if ((state == S_RD_OUT) && !res_full) begin
        head[s_idx] <= ptr_adv(head[s_idx]);
      end
    end
  end

endmodule
`default_nettype wire

/* design/feq_res_queue.sv */
// Result queue: holds finished results until the consumer pops them.
`default_nettype none
module feq_res_queue
  import feq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic res_push,
  input  res_item_t res_in,
  output logic      res_full,
  output logic      empty,
  input  wire logic pop,
  output res_item_t res_out
);

  res_item_t  entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign res_out  = entry[rptr];
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;

  // Storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      entry[wptr] <= res_in;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      case ({wr, rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/fanout_event_queue_drop_oldest.sv */
// Top level of the fan-out event queue with drop-oldest rings.
//
//   Channel   Handshake              Carries
//   input     push / full            command, device, slot, event, max_events
//   config    cfg_valid / cfg_ready  registered_mask
//   result    empty / pop            status, slot, event, summary fields
//
// A single-result command passes through S_EXEC and S_EMIT; a push steps through
// the four reader slots of the device, one slot per cycle, at the single ring write port.
// Reads fetch each event through the registered ring read port and then emit it.
// Reset is synchronous and clears all slot state; ring contents are not cleared.
// Two-entry queues on both sides let input and output stall independently.
`default_nettype none
module fanout_event_queue_drop_oldest
  import feq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         command,
  input  wire logic [1:0]         device,
  input  wire logic [1:0]         client_slot,
  input  wire logic [15:0]        event_type,
  input  wire logic [15:0]        event_code,
  input  wire logic signed [31:0] event_value,
  input  wire logic [63:0]        timestamp,
  input  wire logic [6:0]         max_events,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [3:0]         registered_mask,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              status,
  output logic [1:0]              assigned_slot,
  output logic [15:0]             out_type,
  output logic [15:0]             out_code,
  output logic signed [31:0]      out_value,
  output logic [63:0]             out_timestamp,
  output logic                    last,
  output logic                    has_events,
  output logic                    client_present,
  output logic [31:0]             dropped_count,
  output logic [31:0]             open_sequence
);

  logic      [3:0] mask;
  logic            cmd_valid;
  cmd_item_t       cmd_item;
  logic            cmd_pop;
  logic            res_full;
  logic            res_push;
  res_item_t       res_in;
  res_item_t       res_out;

  // Registration mask register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'd0;
    end else if (cfg_valid) begin
      mask <= registered_mask;
    end
  end

  feq_cmd_queue u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .device      (device),
    .client_slot (client_slot),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .timestamp   (timestamp),
    .max_events  (max_events),
    .cmd_valid   (cmd_valid),
    .cmd_item    (cmd_item),
    .cmd_pop     (cmd_pop)
  );

  feq_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .mask      (mask),
    .cmd_valid (cmd_valid),
    .cmd_item  (cmd_item),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_in)
  );

  feq_res_queue u_results (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .res_out  (res_out)
  );

  // Result fields onto their ports.
  assign status         = res_out.st;
  assign assigned_slot  = res_out.aslot;
  assign out_type       = res_out.otype;
  assign out_code       = res_out.ocode;
  assign out_value      = $signed(res_out.ovalue);
  assign out_timestamp  = res_out.ots;
  assign last           = res_out.last;
  assign has_events     = res_out.has_events;
  assign client_present = res_out.client_present;
  assign dropped_count  = res_out.dropped;
  assign open_sequence  = res_out.oseq;

endmodule
`default_nettype wire
